@@ design/dpbw_pkg.sv @@
package dpbw_pkg;

  // Field widths of the pixel and of the world point.
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned OUT_W   = 24;

  // Sampling grid and coordinate mask.
  localparam int unsigned STEP       = 4;
  localparam int unsigned COORD_BITS = 12;
  localparam logic [PIX_W-1:0] COORD_MASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

  // Grid test by reciprocal: floor(u / STEP) = (u * DIV_MULT) >> DIV_SHIFT,
  // exact for every PIX_W-bit u and STEP up to 16.
  localparam int unsigned DIV_SHIFT = PIX_W + 5;
  localparam logic [DIV_SHIFT:0] DIV_MULT =
    (DIV_SHIFT + 1)'(((1 << DIV_SHIFT) + STEP - 1) / STEP);

  // Camera point widths: x and y in mm Q.8 magnitude up to 2^36, z in mm Q.8.
  localparam int unsigned CAM_W  = 37;
  localparam int unsigned CAMZ_W = 25;
  localparam int unsigned ACC_W  = 56;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_POSE_X      = 3'd0,
    CFG_POSE_Y      = 3'd1,
    CFG_POSE_Z      = 3'd2,
    CFG_INV_FOCAL   = 3'd3,
    CFG_PRINCIPAL   = 3'd4,
    CFG_DEPTH_LIMIT = 3'd5
  } cfg_reg_e;

  // Reset values: identity pose, 1/512 focal reciprocals, depth 300..4000 mm.
  localparam logic [63:0] POSE_X_RST    = 64'h0000_0000_0000_4000;
  localparam logic [63:0] POSE_Y_RST    = 64'h0000_0000_4000_0000;
  localparam logic [63:0] POSE_Z_RST    = 64'h0000_4000_0000_0000;
  localparam logic [63:0] INV_FOCAL_RST = 64'h0080_0000_0080_0000;
  localparam logic [31:0] PRINCIPAL_RST = 32'h0000_0000;
  localparam logic [31:0] DEPTH_LIM_RST = 32'h0FA0_012C;

  // Load enables of the transform stages, shared by the three row units.
  typedef struct packed {
    logic s6;
    logic s7;
    logic s8;
    logic s9;
  } dpbw_adv_t;

endpackage

@@ design/dpbw_row.sv @@
module dpbw_row (
  input  logic                                clk_i,
  input  dpbw_pkg::dpbw_adv_t                 adv_i,
  input  logic                         [63:0] row_i,
  input  logic signed [dpbw_pkg::CAM_W-1:0]   cam_x_i,
  input  logic signed [dpbw_pkg::CAM_W-1:0]   cam_y_i,
  input  logic signed [dpbw_pkg::CAMZ_W-1:0]  cam_z_i,
  output logic        [dpbw_pkg::OUT_W-1:0]   world_o
);
  import dpbw_pkg::*;

  localparam int unsigned PXY_W = CAM_W + 16;
  localparam int unsigned PZ_W  = CAMZ_W + 16;
  localparam int unsigned T_W   = 16 + 22;
  localparam int unsigned W_W   = ACC_W - 22;
  localparam logic signed [ACC_W-1:0] RND_HALF    = ACC_W'(1 << 21);
  localparam logic signed [ACC_W-1:0] RND_HALF_M1 = ACC_W'((1 << 21) - 1);

  logic signed [15:0]       c0, c1, c2;
  logic signed [PXY_W-1:0]  p0_d, p0_q, p1_d, p1_q;
  logic signed [PZ_W-1:0]   p2_d, p2_q;
  logic signed [T_W-1:0]    t_d, t_q;
  logic signed [ACC_W-1:0]  sa_d, sa_q, sb_d, sb_q, acc_d, acc_q, rnd;
  logic        [W_W-1:0]    wide;
  logic        [OUT_W-1:0]  world_d, world_q;

  // Coefficient products and the translation scaled to the product format.
  always_comb begin
    c0   = $signed(row_i[15:0]);
    c1   = $signed(row_i[31:16]);
    c2   = $signed(row_i[47:32]);
    p0_d = c0 * cam_x_i;
    p1_d = c1 * cam_y_i;
    p2_d = c2 * cam_z_i;
    t_d  = $signed({row_i[63:48], 22'b0});
  end

  // Two partial sums, then the full sum.
  always_comb begin
    sa_d  = ACC_W'(p0_q) + ACC_W'(p1_q);
    sb_d  = ACC_W'(p2_q) + ACC_W'(t_q);
    acc_d = sa_q + sb_q;
  end

  // Round half away from zero: floor((acc + 2^21 - neg) / 2^22), then saturate.
  always_comb begin
    rnd  = acc_q + (acc_q[ACC_W-1] ? RND_HALF_M1 : RND_HALF);
    wide = rnd[ACC_W-1:22];
    if (!wide[W_W-1] && (|wide[W_W-2:OUT_W-1])) begin
      world_d = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (wide[W_W-1] && !(&wide[W_W-2:OUT_W-1])) begin
      world_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      world_d = wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s6) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      t_q  <= t_d;
    end
    if (adv_i.s7) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
    if (adv_i.s8) begin
      acc_q <= acc_d;
    end
    if (adv_i.s9) begin
      world_q <= world_d;
    end
  end

  assign world_o = world_q;

endmodule

@@ design/depth_pixel_backproject_to_world.sv @@
// Channel   Dir  Beat fields (low bit first)                 Accept
// s_axis    in   tdata: pixel_col, pixel_row, depth_mm      tvalid & tready
// m_axis    out  tdata: world_x, world_y, world_z           tvalid & tready
// cfg       in   cfg_index_i, cfg_data_i                    cfg_valid_i & cfg_ready_o
//
// Nine register stages; a kept pixel moves through stages 1 to 9 in order and is valid
// on m_axis once it reaches stage 9. One pixel per cycle sustained while m_axis is ready;
// stage 4 holds the 32x32 reciprocal-focal multiply. Dropped pixels turn into bubbles
// that the per-stage ready chain absorbs.
// Reset loads identity pose, 1/512 reciprocals, zero principal point, 300..4000 mm.
// On an m_axis stall, full stages with no empty stage after them hold; others fill the gaps.
module depth_pixel_backproject_to_world (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_col[11:0], pixel_row[23:12], depth_mm[39:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // world_x[23:0], world_y[47:24], world_z[71:48]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import dpbw_pkg::*;

  localparam int unsigned PROD_W = PIX_W + DIV_SHIFT + 1;
  localparam int unsigned CHK_W  = PIX_W + 5;
  localparam logic [63:0] CAM_RND = 64'h0000_0000_0800_0000;

  // Configuration registers.
  logic [63:0] pose_x_q, pose_y_q, pose_z_q, inv_focal_q;
  logic [31:0] principal_q, depth_lim_q;

  // Stage valid bits and ready chain.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;
  dpbw_adv_t adv;

  // Stage payloads.
  logic [PIX_W-1:0]   u1_q, r1_q, u2_q, r2_q, qu2_d, qu2_q, qv2_d, qv2_q;
  logic [DEPTH_W-1:0] z1_q, z2_q, z3_q, z4_q;
  logic [PROD_W-1:0]  prod_u, prod_v;
  logic signed [16:0] du2_d, du2_q, dv2_d, dv2_q;
  logic               range_ok, grid_ok;
  logic [CHK_W-1:0]   back_u, back_v;
  logic [15:0]        mag_u, mag_v;
  logic [31:0]        mx3_d, mx3_q, my3_d, my3_q;
  logic               sx3_q, sy3_q, sx4_q, sy4_q;
  logic [63:0]        px4_d, px4_q, py4_d, py4_q, rx5, ry5;
  logic signed [CAM_W-1:0]  cx5_d, cx5_q, cy5_d, cy5_q;
  logic signed [CAMZ_W-1:0] cz5_q;
  logic [OUT_W-1:0]   wx, wy, wz;

  // Configuration writes; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q    <= POSE_X_RST;
      pose_y_q    <= POSE_Y_RST;
      pose_z_q    <= POSE_Z_RST;
      inv_focal_q <= INV_FOCAL_RST;
      principal_q <= PRINCIPAL_RST;
      depth_lim_q <= DEPTH_LIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_POSE_X:      pose_x_q    <= cfg_data_i;
        CFG_POSE_Y:      pose_y_q    <= cfg_data_i;
        CFG_POSE_Z:      pose_z_q    <= cfg_data_i;
        CFG_INV_FOCAL:   inv_focal_q <= cfg_data_i;
        CFG_PRINCIPAL:   principal_q <= cfg_data_i[31:0];
        CFG_DEPTH_LIMIT: depth_lim_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its successor loads too.
  always_comb begin
    rdy9 = !v9_q || m_axis_tready;
    rdy8 = !v8_q || rdy9;
    rdy7 = !v7_q || rdy8;
    rdy6 = !v6_q || rdy7;
    rdy5 = !v5_q || rdy6;
    rdy4 = !v4_q || rdy5;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    adv.s6 = rdy6;
    adv.s7 = rdy7;
    adv.s8 = rdy8;
    adv.s9 = rdy9;
  end

  assign s_axis_tready = rdy1;

  // Stage 2 logic: depth window, grid quotients, offsets from the principal point.
  always_comb begin
    range_ok = (z1_q >= depth_lim_q[15:0]) && (z1_q <= depth_lim_q[31:16]);
    prod_u   = {{(DIV_SHIFT + 1){1'b0}}, u1_q} * {{PIX_W{1'b0}}, DIV_MULT};
    prod_v   = {{(DIV_SHIFT + 1){1'b0}}, r1_q} * {{PIX_W{1'b0}}, DIV_MULT};
    qu2_d    = prod_u[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
    qv2_d    = prod_v[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
    du2_d    = $signed({1'b0, u1_q, 4'b0}) - $signed({1'b0, principal_q[15:0]});
    dv2_d    = $signed({1'b0, r1_q, 4'b0}) - $signed({1'b0, principal_q[31:16]});
  end

  // Stage 3 logic: grid check and offset magnitude times depth.
  always_comb begin
    back_u  = {5'b0, qu2_q} * CHK_W'(STEP);
    back_v  = {5'b0, qv2_q} * CHK_W'(STEP);
    grid_ok = (back_u == {5'b0, u2_q}) && (back_v == {5'b0, r2_q});
    mag_u   = du2_q[16] ? 16'(-du2_q) : du2_q[15:0];
    mag_v   = dv2_q[16] ? 16'(-dv2_q) : dv2_q[15:0];
    mx3_d   = {16'b0, mag_u} * {16'b0, z2_q};
    my3_d   = {16'b0, mag_v} * {16'b0, z2_q};
  end

  // Stage 4 logic: scale by the focal reciprocals.
  always_comb begin
    px4_d = {32'b0, mx3_q} * {32'b0, inv_focal_q[31:0]};
    py4_d = {32'b0, my3_q} * {32'b0, inv_focal_q[63:32]};
  end

  // Stage 5 logic: round the magnitude, then restore the sign.
  always_comb begin
    rx5   = px4_q + CAM_RND;
    ry5   = py4_q + CAM_RND;
    cx5_d = sx4_q ? -$signed({1'b0, rx5[63:28]}) : $signed({1'b0, rx5[63:28]});
    cy5_d = sy4_q ? -$signed({1'b0, ry5[63:28]}) : $signed({1'b0, ry5[63:28]});
  end

  // Valid bits; dropped pixels leave a bubble.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q && range_ok;
      if (rdy3) v3_q <= v2_q && grid_ok;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
      if (rdy9) v9_q <= v8_q;
    end
  end

  // Payload registers of the camera stages.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      u1_q <= s_axis_tdata[11:0] & COORD_MASK;
      r1_q <= s_axis_tdata[23:12] & COORD_MASK;
      z1_q <= s_axis_tdata[39:24];
    end
    if (rdy2) begin
      u2_q  <= u1_q;
      r2_q  <= r1_q;
      qu2_q <= qu2_d;
      qv2_q <= qv2_d;
      du2_q <= du2_d;
      dv2_q <= dv2_d;
      z2_q  <= z1_q;
    end
    if (rdy3) begin
      mx3_q <= mx3_d;
      my3_q <= my3_d;
      sx3_q <= du2_q[16];
      sy3_q <= dv2_q[16];
      z3_q  <= z2_q;
    end
    if (rdy4) begin
      px4_q <= px4_d;
      py4_q <= py4_d;
      sx4_q <= sx3_q;
      sy4_q <= sy3_q;
      z4_q  <= z3_q;
    end
    if (rdy5) begin
      cx5_q <= cx5_d;
      cy5_q <= cy5_d;
      cz5_q <= $signed({1'b0, z4_q, 8'b0});
    end
  end

  // One transform row per world axis, stages 6 to 9.
  dpbw_row u_row_x (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .row_i   (pose_x_q),
    .cam_x_i (cx5_q),
    .cam_y_i (cy5_q),
    .cam_z_i (cz5_q),
    .world_o (wx)
  );

  dpbw_row u_row_y (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .row_i   (pose_y_q),
    .cam_x_i (cx5_q),
    .cam_y_i (cy5_q),
    .cam_z_i (cz5_q),
    .world_o (wy)
  );

  dpbw_row u_row_z (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .row_i   (pose_z_q),
    .cam_x_i (cx5_q),
    .cam_y_i (cy5_q),
    .cam_z_i (cz5_q),
    .world_o (wz)
  );

  assign m_axis_tvalid = v9_q;
  assign m_axis_tdata  = {wz, wy, wx};

`ifndef SYNTH
  // Input back-pressure only ever comes from a completely full pipeline.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q && v7_q &&
                        v8_q && v9_q))
    else $error("input stalled while a pipeline stage is empty");

  // A pixel that passes the grid check lies on the sampling grid.
  a_grid_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && $past(rdy3)) |-> (($past(u2_q) % STEP) == 0 && ($past(r2_q) % STEP) == 0))
    else $error("off-grid pixel passed the reciprocal grid check");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dpbw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RX_STALL_LEN = 300;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_KEPT   = 45;
  localparam int unsigned STALL_PHASE  = 7;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  // One world point as it travels on m_axis, x in the lowest bits.
  typedef struct packed {
    logic [OUT_W-1:0] wz;
    logic [OUT_W-1:0] wy;
    logic [OUT_W-1:0] wx;
  } world_pt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // pixel_col[11:0], pixel_row[23:12], depth_mm[39:24]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // world_x[23:0], world_y[47:24], world_z[71:48]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // Shadow copy of the configuration registers.
  logic [63:0] pose_row [3] = '{POSE_X_RST, POSE_Y_RST, POSE_Z_RST};
  logic [63:0] inv_focal_r = INV_FOCAL_RST;
  logic [31:0] principal_r = PRINCIPAL_RST;
  logic [31:0] depth_lim_r = DEPTH_LIM_RST;

  logic [39:0] pixel_beats_q [$];
  world_pt_t   world_pts_due [$];
  logic        pix_fire = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_stall_req = 1'b0;
  int unsigned rx_stall_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned kept_cnt = 0;

  depth_pixel_backproject_to_world DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Camera coordinate in mm Q.8: round(dq * z * inv / 2^28), halves away from zero.
  function automatic longint cam_scale(input longint dq, input logic [15:0] z,
                                       input logic [31:0] inv);
    longint      p;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    p = dq * longint'(z);
    m = (p < 0) ? -p : p;
    a = m * 64'(inv[31:16]);
    b = m * 64'(inv[15:0]) + (64'd1 << 27);
    q = (a + (b >> 16)) >> 12;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  // One row of the rigid transform, rounded from Q.22 and clamped to 24 bits.
  function automatic logic [OUT_W-1:0] transform_row(input logic [63:0] row,
                                                     input longint x, input longint y,
                                                     input longint z);
    longint      acc;
    longint      w;
    logic [63:0] mag;
    logic [63:0] r;
    acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y +
          longint'($signed(row[47:32])) * z + longint'($signed(row[63:48])) * (64'sd1 <<< 22);
    mag = (acc < 0) ? -acc : acc;
    r = (mag + (64'd1 << 21)) >> 22;
    w = (acc < 0) ? -longint'(r) : longint'(r);
    if (w > 64'sd8388607) w = 64'sd8388607;
    if (w < -64'sd8388608) w = -64'sd8388608;
    return w[OUT_W-1:0];
  endfunction

  // Returns 1 and the world point when the pixel is on the grid and in the depth range.
  function automatic bit project_pixel(input logic [39:0] beat, output world_pt_t pt);
    logic [PIX_W-1:0]   u;
    logic [PIX_W-1:0]   v;
    logic [DEPTH_W-1:0] d;
    longint             cx;
    longint             cy;
    longint             cz;
    pt = '0;
    u = beat[11:0] & COORD_MASK;
    v = beat[23:12] & COORD_MASK;
    d = beat[39:24];
    if ((u % STEP) != 0 || (v % STEP) != 0) return 1'b0;
    if (d < depth_lim_r[15:0] || d > depth_lim_r[31:16]) return 1'b0;
    cx = cam_scale(longint'(u) * 16 - longint'(principal_r[15:0]), d, inv_focal_r[31:0]);
    cy = cam_scale(longint'(v) * 16 - longint'(principal_r[31:16]), d, inv_focal_r[63:32]);
    cz = longint'(d) * 256;
    pt.wx = transform_row(pose_row[0], cx, cy, cz);
    pt.wy = transform_row(pose_row[1], cx, cy, cz);
    pt.wz = transform_row(pose_row[2], cx, cy, cz);
    return 1'b1;
  endfunction

  function automatic void check_coord(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
      err_cnt++;
    end
  endfunction

  // Pixel driver: a new beat is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || pix_fire)) begin
      if (pixel_beats_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tdata  <= pixel_beats_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver ready, with one long hold-off counted here.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_req && rx_stall_cnt < RX_STALL_LEN) begin
      rx_stall_cnt  <= rx_stall_cnt + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: predict on every accepted pixel, check every accepted world point.
  always @(posedge clk_i) begin
    world_pt_t pt;
    world_pt_t got;
    pix_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (world_pts_due.size() == 0) begin
          $error("world point %h with no pixel waiting for it", m_axis_tdata);
          err_cnt++;
        end else begin
          pt = world_pts_due.pop_front();
          check_coord("world_x", pt.wx, got.wx);
          check_coord("world_y", pt.wy, got.wy);
          check_coord("world_z", pt.wz, got.wz);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (project_pixel(s_axis_tdata, pt)) world_pts_due.push_back(pt);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_POSE_X:      pose_row[0] = val;
      CFG_POSE_Y:      pose_row[1] = val;
      CFG_POSE_Z:      pose_row[2] = val;
      CFG_INV_FOCAL:   inv_focal_r = val;
      CFG_PRINCIPAL:   principal_r = val[31:0];
      CFG_DEPTH_LIMIT: depth_lim_r = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pixel is sent and every world point is back, then let
  // dropped pixels leave the pipeline.
  task automatic wait_drained();
    while (pixel_beats_q.size() != 0 || s_axis_tvalid || world_pts_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_pixel(input int unsigned u, input int unsigned v, input int unsigned d);
    logic [39:0] beat;
    world_pt_t   pt;
    beat = {d[15:0], v[11:0], u[11:0]};
    pixel_beats_q.push_back(beat);
    if (project_pixel(beat, pt)) kept_cnt++;
  endtask

  // Mostly grid pixels inside the depth window, the rest raw noise.
  task automatic add_random_pixel();
    int unsigned u;
    int unsigned v;
    int unsigned d;
    int unsigned lo;
    int unsigned hi;
    u = $urandom_range(0, 4095);
    v = $urandom_range(0, 4095);
    d = $urandom_range(0, 65535);
    lo = depth_lim_r[15:0];
    hi = depth_lim_r[31:16];
    if ($urandom_range(0, 99) < 75) begin
      u -= u % STEP;
      v -= v % STEP;
      if (lo <= hi) begin
        case ($urandom_range(0, 9))
          0:       d = lo;
          1:       d = hi;
          default: d = $urandom_range(lo, hi);
        endcase
      end
    end
    add_pixel(u, v, d);
  endtask

  function automatic logic [63:0] rand_pose_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      r[15:0]  = 16'($urandom_range(0, 32768) - 16384);
      r[31:16] = 16'($urandom_range(0, 32768) - 16384);
      r[47:32] = 16'($urandom_range(0, 32768) - 16384);
    end
    return r;
  endfunction

  task automatic write_random_config();
    logic [63:0] inv;
    logic [31:0] pp;
    logic [31:0] lim;
    int unsigned lo;
    int unsigned hi;
    inv = {$urandom, $urandom};
    if ($urandom_range(0, 1))
      inv = {32'($urandom_range(1 << 20, 1 << 24)), 32'($urandom_range(1 << 20, 1 << 24))};
    pp = $urandom;
    if ($urandom_range(0, 1))
      pp = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))} & 32'h0FFF_0FFF;
    lo = $urandom_range(0, 1500);
    hi = $urandom_range(lo + 500, 65535);
    case ($urandom_range(0, 9))
      0, 1:    lim = $urandom;
      2:       lim = 32'hFFFF_0000;
      default: lim = {hi[15:0], lo[15:0]};
    endcase
    write_reg(CFG_POSE_X, rand_pose_row());
    write_reg(CFG_POSE_Y, rand_pose_row());
    write_reg(CFG_POSE_Z, rand_pose_row());
    write_reg(CFG_INV_FOCAL, inv);
    write_reg(CFG_PRINCIPAL, {$urandom, pp});
    write_reg(CFG_DEPTH_LIMIT, {$urandom, lim});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
  endtask

  initial begin
    int unsigned target;
    int unsigned pushed;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: depth window edges, grid edges, coordinate extremes.
    tx_idle_pct = 6;
    rx_idle_pct = 46;
    add_pixel(0, 0, 300);
    add_pixel(0, 0, 4000);
    add_pixel(0, 0, 299);
    add_pixel(0, 0, 4001);
    add_pixel(4092, 4092, 300);
    add_pixel(4095, 0, 1000);
    add_pixel(0, 4095, 1000);
    add_pixel(2, 4, 1000);
    add_pixel(4, 1, 1000);
    add_pixel(4092, 4092, 4000);
    add_pixel(0, 0, 0);
    add_pixel(4, 4, 65535);
    add_pixel(2048, 1024, 1500);
    wait_drained();

    // Extreme coefficients, translations, reciprocals and principal point.
    write_reg(CFG_POSE_X, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(CFG_POSE_Y, 64'h8000_8000_8000_8000);
    write_reg(CFG_POSE_Z, 64'h0000_8000_7FFF_0000);
    write_reg(CFG_INV_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRINCIPAL, 64'h0000_0000_FFFF_FFFF);
    write_reg(CFG_DEPTH_LIMIT, 64'h0000_0000_FFFF_0000);
    add_pixel(0, 0, 65535);
    add_pixel(4092, 4092, 65535);
    add_pixel(0, 0, 0);
    add_pixel(4092, 0, 1);
    add_pixel(0, 4092, 32768);
    wait_drained();

    // Spare indexes, an empty window with min above max, then a one-value window.
    write_reg(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_DEPTH_LIMIT, {32'd0, 16'd100, 16'd5000});
    add_pixel(0, 0, 100);
    add_pixel(0, 0, 5000);
    add_pixel(8, 8, 2000);
    wait_drained();
    write_reg(CFG_INV_FOCAL, 64'd0);
    write_reg(CFG_DEPTH_LIMIT, {32'd0, 16'd777, 16'd777});
    add_pixel(8, 8, 777);
    add_pixel(8, 8, 778);
    wait_drained();

    // Random phases, each with its own configuration and idle pattern.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_random_config();
      if (ph < 3) begin
        tx_idle_pct = 6;
        rx_idle_pct = 46;
      end else if (ph < 6) begin
        tx_idle_pct = 46;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Wide window so the hold-off backs the pipeline up to its input.
      if (ph == STALL_PHASE) begin
        write_reg(CFG_DEPTH_LIMIT, 64'h0000_0000_FFFF_0000);
        rx_stall_req = 1'b1;
      end
      target = kept_cnt + PHASE_KEPT;
      pushed = 0;
      while (kept_cnt < target && pushed < 4 * PHASE_KEPT) begin
        add_random_pixel();
        pushed++;
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ depth_pixel_backproject_to_world.f @@
design/dpbw_pkg.sv
design/dpbw_row.sv
design/depth_pixel_backproject_to_world.sv
verif/tb_top.sv
